// ===== sv/lfuc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuc_pkg
// Shared types and constants of the least-frequently-used cache table.
// ----------------------------------------------------------------------------
package lfuc_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int VALUE_BITS_DEF = 64;
	localparam int COUNT_BITS_DEF = 16;

	localparam int KEY_BITS   = 32;
	localparam int STAMP_BITS = 32;
	localparam int CMD_BITS   = 2;
	localparam int DATA_BITS  = 64;
	localparam int CFG_BITS   = 5;
	localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

	typedef enum logic [CMD_BITS-1:0] {
		OP_GET    = 2'd0,
		OP_UPDATE = 2'd1,
		OP_ADD    = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

// ===== sv/lfuc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuc_ctrl
// Sequencer: takes a transaction, scans all slots, then commits the result.
// ----------------------------------------------------------------------------
module lfuc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  lfuc_pkg::dp_status_t   sts,
	output lfuc_pkg::ctrl_cmd_t    ctl
);
	import lfuc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			// The last slot read is compared during this cycle.
			ST_DRAIN: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (sts.out_free) begin
					ctl.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> state_q == ST_SCAN)
		else $error("load did not start a scan");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> in_ready)
		else $error("commit did not return to idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load, ctl.step, ctl.commit}))
		else $error("conflicting datapath commands");

endmodule

// ===== sv/lfuc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuc_dp
// Slot memory, valid bits, scan comparators and result register.
// ----------------------------------------------------------------------------
module lfuc_dp #(
	parameter int CAPACITY   = lfuc_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = lfuc_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = lfuc_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lfuc_pkg::ctrl_cmd_t              ctl,
	output lfuc_pkg::dp_status_t             sts,
	input  logic                             cfg_we,
	input  logic [lfuc_pkg::CFG_BITS-1:0]    cfg_wdata,
	input  logic [lfuc_pkg::CMD_BITS-1:0]    in_cmd,
	input  logic [lfuc_pkg::KEY_BITS-1:0]    in_key,
	input  logic [lfuc_pkg::DATA_BITS-1:0]   in_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             out_hit,
	output logic [lfuc_pkg::DATA_BITS-1:0]   out_read_value,
	output logic                             out_evicted,
	output logic [lfuc_pkg::KEY_BITS-1:0]    out_evicted_key
);
	import lfuc_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int UW = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		logic [COUNT_BITS-1:0] count;
		logic [STAMP_BITS-1:0] stamp;
	} entry_t;

	entry_t                mem [CAPACITY];
	logic [CAPACITY-1:0]   valid_q;
	logic [CFG_BITS-1:0]   cap_q;
	logic [STAMP_BITS-1:0] stamp_q;

	op_t                   cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [IW-1:0]         idx_q;

	logic                  rd_vld_s1;
	logic [IW-1:0]         rd_idx_s1;
	entry_t                rd_data_s1;

	logic                  m_found_q;
	logic [IW-1:0]         m_idx_q;
	entry_t                m_ent_q;
	logic [UW-1:0]         used_q;
	logic                  f_found_q;
	logic [IW-1:0]         f_idx_q;
	logic                  v_found_q;
	logic [IW-1:0]         v_idx_q;
	logic [KEY_BITS-1:0]   v_key_q;
	logic [COUNT_BITS-1:0] v_cnt_q;
	logic [STAMP_BITS-1:0] v_age_q;

	logic                  out_valid_q;
	logic                  out_hit_q;
	logic [DATA_BITS-1:0]  out_read_value_q;
	logic                  out_evicted_q;
	logic [KEY_BITS-1:0]   out_evicted_key_q;

	logic                  slot_ok;
	logic [STAMP_BITS-1:0] age;
	logic                  better;
	logic [31:0]           cap_ext, cap_lim;
	logic                  need_evict, do_insert;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  wr_en, set_valid, bump;
	logic [IW-1:0]         wr_idx;
	entry_t                wr_ent;
	logic [DATA_BITS-1:0]  o_read;
	logic                  o_ev;
	logic [KEY_BITS-1:0]   o_evk;

	assign sts.scan_last = (idx_q == IW'(CAPACITY - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	// Scan comparisons on the slot read in the previous cycle.
	assign slot_ok = rd_vld_s1 && valid_q[rd_idx_s1];
	assign age     = stamp_q - rd_data_s1.stamp;
	assign better  = !v_found_q || (rd_data_s1.count < v_cnt_q) ||
		((rd_data_s1.count == v_cnt_q) && (age > v_age_q));

	// Capacities above the slot count act as the slot count.
	assign cap_ext    = 32'(cap_q);
	assign cap_lim    = (cap_ext > 32'(CAPACITY)) ? 32'(CAPACITY) : cap_ext;
	assign need_evict = (32'(used_q) >= cap_lim) || !f_found_q;
	assign do_insert  = need_evict ? v_found_q : f_found_q;
	assign cnt_inc    = (m_ent_q.count == '1) ? m_ent_q.count : m_ent_q.count + 1'b1;

	always_comb begin
		wr_en     = 1'b0;
		set_valid = 1'b0;
		bump      = 1'b0;
		wr_idx    = m_idx_q;
		wr_ent    = m_ent_q;
		o_read    = '0;
		o_ev      = 1'b0;
		o_evk     = '0;
		case (cmd_q)
			OP_GET: begin
				if (m_found_q) begin
					wr_en        = 1'b1;
					bump         = 1'b1;
					wr_ent.count = cnt_inc;
					wr_ent.stamp = stamp_q;
					o_read       = DATA_BITS'(m_ent_q.value);
				end
			end
			OP_UPDATE: begin
				if (m_found_q) begin
					wr_en        = 1'b1;
					wr_ent.value = val_q;
				end
			end
			OP_ADD: begin
				if (cap_lim != 32'd0) begin
					if (m_found_q) begin
						wr_en        = 1'b1;
						bump         = 1'b1;
						wr_ent.value = val_q;
						wr_ent.count = cnt_inc;
						wr_ent.stamp = stamp_q;
					end else if (do_insert) begin
						wr_en        = 1'b1;
						set_valid    = 1'b1;
						bump         = 1'b1;
						wr_idx       = need_evict ? v_idx_q : f_idx_q;
						wr_ent.key   = key_q;
						wr_ent.value = val_q;
						wr_ent.count = COUNT_BITS'(1);
						wr_ent.stamp = stamp_q;
						if (need_evict) begin
							o_ev  = 1'b1;
							o_evk = v_key_q;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Slot memory: one read and one write port, read data registered.
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			rd_data_s1 <= mem[idx_q];
		end
		if (ctl.commit && wr_en) begin
			mem[wr_idx] <= wr_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			cap_q       <= CAP_RESET;
			stamp_q     <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			rd_vld_s1 <= ctl.step;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
				if (set_valid) begin
					valid_q[wr_idx] <= 1'b1;
				end
				if (bump) begin
					stamp_q <= stamp_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q     <= op_t'(in_cmd);
			key_q     <= in_key;
			val_q     <= in_value[VALUE_BITS-1:0];
			idx_q     <= '0;
			m_found_q <= 1'b0;
			used_q    <= '0;
			f_found_q <= 1'b0;
			v_found_q <= 1'b0;
		end else begin
			if (ctl.step) begin
				idx_q     <= idx_q + 1'b1;
				rd_idx_s1 <= idx_q;
			end
			if (slot_ok) begin
				used_q <= used_q + 1'b1;
				if (rd_data_s1.key == key_q) begin
					m_found_q <= 1'b1;
					m_idx_q   <= rd_idx_s1;
					m_ent_q   <= rd_data_s1;
				end
				if (better) begin
					v_found_q <= 1'b1;
					v_idx_q   <= rd_idx_s1;
					v_key_q   <= rd_data_s1.key;
					v_cnt_q   <= rd_data_s1.count;
					v_age_q   <= age;
				end
			end else if (rd_vld_s1 && !f_found_q) begin
				f_found_q <= 1'b1;
				f_idx_q   <= rd_idx_s1;
			end
		end
		if (ctl.commit) begin
			out_hit_q         <= (cmd_q != OP_NONE) && m_found_q;
			out_read_value_q  <= o_read;
			out_evicted_q     <= o_ev;
			out_evicted_key_q <= o_evk;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_hit         = out_hit_q;
	assign out_read_value  = out_read_value_q;
	assign out_evicted     = out_evicted_q;
	assign out_evicted_key = out_evicted_key_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_evicted_q |-> !out_hit_q)
		else $error("eviction reported on a hit");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_hit_q |-> out_read_value_q == '0)
		else $error("read value without a hit");

	assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.commit |=> $stable(stamp_q))
		else $error("stamp moved outside a commit");

endmodule

// ===== sv/lfu_cache_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_table
// Fully associative key-value cache with least-frequently-used replacement.
// ----------------------------------------------------------------------------
// Input transactions arrive on s_axis: tuser carries the command (get, update,
// add), tdata the key and the value word. Each transaction yields exactly one
// result on m_axis: tuser carries hit and evicted, tdata the read value and
// the evicted key. cfg_we/cfg_wdata write the capacity in use; the user
// must write it only while idle, as the block itself does not enforce this.
// An accepted transaction reads every slot through the single read port of
// the slot memory, one slot per cycle, then decides and writes back once; the
// block takes no new transaction until the last one is written back.
// s_axis_tready is high only while the sequencer is idle.
// If the receiver stalls, the result waits in the output register; the next
// transaction is still accepted and scanned, and its write-back waits until
// the output register is free.
// Reset empties the cache (all slots invalid), sets the capacity in use to 16
// and clears the recency stamp; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
	parameter int CAPACITY   = lfuc_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = lfuc_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = lfuc_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [95:0]                   s_axis_tdata,  // lookup_key, write_value
	input  logic [1:0]                    s_axis_tuser,  // cmd
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [95:0]                   m_axis_tdata,  // read_value, evicted_key
	output logic [1:0]                    m_axis_tuser,  // hit, evicted
	input  logic                          cfg_we,
	input  logic [lfuc_pkg::CFG_BITS-1:0] cfg_wdata
);
	import lfuc_pkg::*;

	ctrl_cmd_t  ctl;
	dp_status_t sts;
	logic       hit, evicted;

	lfuc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	lfuc_dp #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_cmd          (s_axis_tuser),
		.in_key          (s_axis_tdata[31:0]),
		.in_value        (s_axis_tdata[95:32]),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_hit         (hit),
		.out_read_value  (m_axis_tdata[63:0]),
		.out_evicted     (evicted),
		.out_evicted_key (m_axis_tdata[95:64])
	);

	assign m_axis_tuser = {evicted, hit};

endmodule
